>>> rtl/access_log_line_field_parser_macros.svh
// assertion macros for the access log line parser
`ifndef ACCESS_LOG_LINE_FIELD_PARSER_MACROS_SVH
`define ACCESS_LOG_LINE_FIELD_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define ALFP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ALFP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ALFP_ASSERT_IMP(lbl, ante, cons)
`define ALFP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/alfp_pkg.sv
// types, byte codes and match functions of the access log line parser
`default_nettype none
package alfp_pkg;

	localparam int BODY_W = 32;
	localparam int BODY_X_W = BODY_W + 4;

	localparam logic [3:0] FIELD_ADDR   = 4'd0;
	localparam logic [3:0] FIELD_USER   = 4'd1;
	localparam logic [3:0] FIELD_TIME   = 4'd2;
	localparam logic [3:0] FIELD_REQ    = 4'd3;
	localparam logic [3:0] FIELD_STATUS = 4'd4;
	localparam logic [3:0] FIELD_BODY   = 4'd5;
	localparam logic [3:0] FIELD_REF    = 4'd6;
	localparam logic [3:0] FIELD_AGENT  = 4'd7;
	localparam logic [3:0] FIELD_FWD    = 4'd8;

	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_COLON  = 8'd58;
	localparam logic [7:0] CH_A      = 8'd97;
	localparam logic [7:0] CH_F      = 8'd102;
	localparam logic [7:0] CH_DOT    = 8'd46;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_LBRACK = 8'd91;
	localparam logic [7:0] CH_RBRACK = 8'd93;
	localparam logic [7:0] CH_QUOTE  = 8'd34;
	localparam logic [7:0] CH_DASH   = 8'd45;

	localparam logic [2:0] STATUS_DIGITS = 3'd3;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_RUN    = 3'd1,
		PH_INSIDE = 3'd2,
		PH_PRE    = 3'd3,
		PH_DASH   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [3:0]        field;
		phase_t            phase;
		logic              failed;
		logic              complete;
		logic [9:0]        status_acc;
		logic [2:0]        status_cnt;
		logic [BODY_W-1:0] body;
		logic              body_ovf;
	} state_t;

	localparam state_t STATE_RESET = '{
		field: FIELD_ADDR, phase: PH_LEAD, failed: 1'b0, complete: 1'b0,
		status_acc: '0, status_cnt: '0, body: '0, body_ovf: 1'b0
	};

	typedef struct packed {
		logic        in_value;
		logic [3:0]  value_field;
		logic        field_done;
		logic [3:0]  done_field;
		logic        line_end;
		logic        line_ok;
		logic [9:0]  status_value;
		logic [31:0] body_bytes;
		logic        body_saturated;
	} result_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_wrapped(input logic [3:0] f);
		return (f == FIELD_TIME) || (f == FIELD_REQ) || (f == FIELD_REF) ||
			(f == FIELD_AGENT) || (f == FIELD_FWD);
	endfunction

	function automatic logic run_match(input logic [3:0] f, input logic [7:0] b);
		logic m;
		if (f == FIELD_ADDR) begin
			m = ((b >= CH_ZERO) && (b <= CH_COLON)) || (b == CH_DOT) ||
				((b >= CH_A) && (b <= CH_F));
		end else if (f == FIELD_USER) begin
			m = (b != CH_SPACE);
		end else begin
			m = is_digit(b);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

>>> rtl/alfp_step.sv
// per-byte next-state and result logic of the parser
`default_nettype none
module alfp_step
	import alfp_pkg::*;
(
	input  state_t      cur,
	input  logic [7:0]  line_byte,
	input  logic        last_byte,
	output state_t      nxt,
	output result_t     res
);

	logic [7:0]          diff;
	logic [3:0]          d;
	logic [3:0]          f;
	logic [7:0]          open_ch;
	logic [7:0]          close_ch;
	logic                do_run;
	logic                do_finish;
	logic [13:0]         st_x;
	logic [BODY_X_W-1:0] body_x;
	logic [BODY_X_W-1:0] body_max_x;
	logic [63:0]         body_wide;

	assign diff = line_byte - CH_ZERO;
	assign d = diff[3:0];
	assign f = cur.field;
	assign open_ch = (f == FIELD_TIME) ? CH_LBRACK : CH_QUOTE;
	assign close_ch = (f == FIELD_TIME) ? CH_RBRACK : CH_QUOTE;

	// x*10 + d as shift-add
	assign st_x = (14'(cur.status_acc) << 3) + (14'(cur.status_acc) << 1) + 14'(d);
	assign body_x = (BODY_X_W'(cur.body) << 3) + (BODY_X_W'(cur.body) << 1)
		+ BODY_X_W'(d);
	assign body_max_x = BODY_X_W'({BODY_W{1'b1}});

	always_comb begin
		nxt = cur;
		res = '0;
		do_run = 1'b0;
		do_finish = 1'b0;
		if (!cur.failed && !cur.complete) begin
			if (f > FIELD_FWD) begin
				nxt.failed = 1'b1;
			end else if (is_wrapped(f)) begin
				if (cur.phase == PH_INSIDE) begin
					if (line_byte == close_ch) begin
						do_finish = 1'b1;
					end else begin
						res.in_value = 1'b1;
						res.value_field = f;
					end
				end else if (line_byte == open_ch) begin
					nxt.phase = PH_INSIDE;
				end else if (line_byte != CH_SPACE) begin
					nxt.failed = 1'b1;
				end
			end else if (cur.phase == PH_RUN) begin
				if (run_match(f, line_byte)) begin
					do_run = 1'b1;
				end else begin
					do_finish = 1'b1;
				end
			end else if ((cur.phase == PH_PRE || cur.phase == PH_DASH) &&
					line_byte == CH_DASH) begin
				nxt.phase = PH_DASH;
			end else if (line_byte == CH_SPACE) begin
				if (cur.phase == PH_DASH) begin
					nxt.phase = PH_LEAD;
				end
			end else if (run_match(f, line_byte)) begin
				do_run = 1'b1;
			end else begin
				nxt.failed = 1'b1;
			end
		end

		if (do_run) begin
			res.in_value = 1'b1;
			res.value_field = f;
			nxt.phase = PH_RUN;
			if (f == FIELD_STATUS) begin
				if (cur.status_cnt < STATUS_DIGITS) begin
					nxt.status_acc = st_x[9:0];
				end
				if (cur.status_cnt <= STATUS_DIGITS) begin
					nxt.status_cnt = cur.status_cnt + 3'd1;
				end
			end else if (f == FIELD_BODY) begin
				if (body_x > body_max_x) begin
					nxt.body = '1;
					nxt.body_ovf = 1'b1;
				end else begin
					nxt.body = body_x[BODY_W-1:0];
				end
			end
			if (last_byte) begin
				do_finish = 1'b1;
			end
		end

		// digit count is checked after this byte's digit is taken
		if (do_finish) begin
			if (f == FIELD_STATUS && nxt.status_cnt != STATUS_DIGITS) begin
				nxt.failed = 1'b1;
			end else begin
				res.field_done = 1'b1;
				res.done_field = f;
				if (f == FIELD_FWD) begin
					nxt.complete = 1'b1;
				end else begin
					nxt.field = f + 4'd1;
					nxt.phase = (f == FIELD_ADDR) ? PH_PRE : PH_LEAD;
				end
			end
		end

		body_wide = 64'(nxt.body);
		if (last_byte) begin
			res.line_end = 1'b1;
			res.line_ok = nxt.complete && !nxt.failed;
			if (res.line_ok) begin
				res.status_value = nxt.status_acc;
				res.body_bytes = body_wide[31:0];
				res.body_saturated = nxt.body_ovf;
			end
			nxt = STATE_RESET;
		end
	end

endmodule
`default_nettype wire

>>> rtl/access_log_line_field_parser.sv
// top level: input register, line state and result register of the parser
// the result passes the input register, then the result register, and is held there until taken
// throughput: one byte per cycle unless out_ready holds a full result register, set by the combinational state update
// the input register refills while a result waits, stalling only when both are full
// reset: arst_n clears valids and returns the line state to the client address field
`default_nettype none
`include "access_log_line_field_parser_macros.svh"
module access_log_line_field_parser
	import alfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  line_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        in_value,
	output logic [3:0]  value_field,
	output logic        field_done,
	output logic [3:0]  done_field,
	output logic        line_end,
	output logic        line_ok,
	output logic [9:0]  status_value,
	output logic [31:0] body_bytes,
	output logic        body_saturated
);

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;
	result_t    res_s2;
	logic       v_s2;
	logic       adv;
	logic       load;

	assign adv = !v_s2 || out_ready;
	assign load = v_s1 && adv;
	assign in_ready = !v_s1 || adv;

	alfp_step u_step (
		.cur      (state_q),
		.line_byte(byte_s1),
		.last_byte(last_s1),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			state_q <= STATE_RESET;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
			if (load) begin
				state_q <= state_nxt;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= line_byte;
			last_s1 <= last_byte;
		end
		if (load) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid = v_s2;
	assign in_value = res_s2.in_value;
	assign value_field = res_s2.value_field;
	assign field_done = res_s2.field_done;
	assign done_field = res_s2.done_field;
	assign line_end = res_s2.line_end;
	assign line_ok = res_s2.line_ok;
	assign status_value = res_s2.status_value;
	assign body_bytes = res_s2.body_bytes;
	assign body_saturated = res_s2.body_saturated;

	`ALFP_ASSERT_IMP(a_empty_out_ready, !v_s2, in_ready)
	`ALFP_ASSERT_IMP(a_ok_only_at_end, v_s2 && line_ok, line_end)
	`ALFP_ASSERT_IMP(a_zero_unless_ok, v_s2 && !line_ok,
		status_value == 10'd0 && body_bytes == 32'd0 && !body_saturated)
	`ALFP_ASSERT_NXT(a_line_clears, load && res_nxt.line_end, state_q == STATE_RESET)

endmodule
`default_nettype wire

>>> test/tb_access_log_line_field_parser.sv
// testbench for the access log line field parser: byte streams, predictor and result checks
`timescale 1ns / 1ps

module tb_access_log_line_field_parser;
	import alfp_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 4;
	localparam int RANDOM_ITEMS = 1850;
	localparam int HOLD_CYCLES  = 64;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [63:0] BODY_MAX = (64'd1 << BODY_W) - 64'd1;

	// expected result per byte, kept in transfer order
	class log_line_scoreboard;
		logic [3:0]  cur_field;
		phase_t      cur_phase;
		logic        line_bad;
		logic        line_done;
		logic [9:0]  status_sum;
		logic [2:0]  status_digits;
		logic [63:0] body_sum;
		logic        body_clipped;
		result_t     pending_results[$];
		int          live_bytes;
		int          errors;

		function new();
			clear_line();
			live_bytes = 0;
			errors = 0;
		endfunction

		function void clear_line();
			cur_field = FIELD_ADDR;
			cur_phase = PH_LEAD;
			line_bad = 1'b0;
			line_done = 1'b0;
			status_sum = '0;
			status_digits = '0;
			body_sum = '0;
			body_clipped = 1'b0;
		endfunction

		static function logic run_char_ok(logic [3:0] f, logic [7:0] b);
			if (f == FIELD_ADDR) begin
				return (b >= CH_ZERO && b <= CH_COLON) || b == CH_DOT || (b >= CH_A && b <= CH_F);
			end
			if (f == FIELD_USER) begin
				return b != CH_SPACE;
			end
			return b >= CH_ZERO && b <= CH_NINE;
		endfunction

		static function logic bracketed(logic [3:0] f);
			return f == FIELD_TIME || f == FIELD_REQ || f == FIELD_REF || f == FIELD_AGENT ||
				f == FIELD_FWD;
		endfunction

		function void add_digit(logic [3:0] f, logic [7:0] b);
			logic [63:0] d;
			d = 64'(b - CH_ZERO);
			if (f == FIELD_STATUS) begin
				if (status_digits < STATUS_DIGITS) begin
					status_sum = 10'(status_sum * 10 + d[9:0]);
				end
				if (status_digits < 3'd4) begin
					status_digits = status_digits + 3'd1;
				end
			end else if (f == FIELD_BODY) begin
				if (body_sum > (BODY_MAX - d) / 10) begin
					body_sum = BODY_MAX;
					body_clipped = 1'b1;
				end else begin
					body_sum = body_sum * 10 + d;
				end
			end
		endfunction

		function void close_field(logic [3:0] f, inout result_t r);
			if (f == FIELD_STATUS && status_digits != STATUS_DIGITS) begin
				line_bad = 1'b1;
				return;
			end
			r.field_done = 1'b1;
			r.done_field = f;
			if (f == FIELD_FWD) begin
				line_done = 1'b1;
			end else begin
				cur_field = f + 4'd1;
				cur_phase = (cur_field == FIELD_USER) ? PH_PRE : PH_LEAD;
			end
		endfunction

		function void take_run_byte(logic [3:0] f, logic [7:0] b, logic last, inout result_t r);
			r.in_value = 1'b1;
			r.value_field = f;
			add_digit(f, b);
			cur_phase = PH_RUN;
			if (last) begin
				close_field(f, r);
			end
		endfunction

		function void parse_byte(logic [7:0] b, logic last, inout result_t r);
			logic [3:0] f;
			phase_t p;
			logic [7:0] open_mark;
			logic [7:0] close_mark;
			f = cur_field;
			p = cur_phase;
			if (f > FIELD_FWD) begin
				line_bad = 1'b1;
				return;
			end
			if (bracketed(f)) begin
				open_mark = (f == FIELD_TIME) ? CH_LBRACK : CH_QUOTE;
				close_mark = (f == FIELD_TIME) ? CH_RBRACK : CH_QUOTE;
				if (p == PH_INSIDE) begin
					if (b == close_mark) begin
						close_field(f, r);
					end else begin
						r.in_value = 1'b1;
						r.value_field = f;
					end
				end else if (b == open_mark) begin
					cur_phase = PH_INSIDE;
				end else if (b != CH_SPACE) begin
					line_bad = 1'b1;
				end
				return;
			end
			if (p == PH_RUN) begin
				// the first byte that does not fit ends the run and is swallowed
				if (run_char_ok(f, b)) begin
					take_run_byte(f, b, last, r);
				end else begin
					close_field(f, r);
				end
				return;
			end
			if ((p == PH_PRE || p == PH_DASH) && b == CH_DASH) begin
				cur_phase = PH_DASH;
				return;
			end
			if (b == CH_SPACE) begin
				if (p == PH_DASH) begin
					cur_phase = PH_LEAD;
				end
				return;
			end
			if (run_char_ok(f, b)) begin
				take_run_byte(f, b, last, r);
			end else begin
				line_bad = 1'b1;
			end
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			result_t r;
			r = '0;
			live_bytes++;
			if (!line_bad && !line_done) begin
				parse_byte(b, last, r);
			end
			if (last) begin
				r.line_end = 1'b1;
				r.line_ok = line_done && !line_bad;
				if (r.line_ok) begin
					r.status_value = status_sum;
					r.body_bytes = body_sum[31:0];
					r.body_saturated = body_clipped;
				end
				clear_line();
			end
			pending_results.push_back(r);
		endfunction

		function void compare(string what, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t %s: expected %0d, actual %0d", $time, what, e, a);
			end
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t result with nothing pending: expected none, actual %h", $time, got);
				return;
			end
			e = pending_results.pop_front();
			compare("in_value", e.in_value, got.in_value);
			compare("value_field", e.value_field, got.value_field);
			compare("field_done", e.field_done, got.field_done);
			compare("done_field", e.done_field, got.done_field);
			compare("line_end", e.line_end, got.line_end);
			compare("line_ok", e.line_ok, got.line_ok);
			compare("status_value", e.status_value, got.status_value);
			compare("body_bytes", e.body_bytes, got.body_bytes);
			compare("body_saturated", e.body_saturated, got.body_saturated);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  line_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        in_value;
	logic [3:0]  value_field;
	logic        field_done;
	logic [3:0]  done_field;
	logic        line_end;
	logic        line_ok;
	logic [9:0]  status_value;
	logic [31:0] body_bytes;
	logic        body_saturated;

	log_line_scoreboard sb = new;
	logic [7:0] line_q[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 0;
	int stall_cycles = 0;

	access_log_line_field_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.line_byte      (line_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.in_value       (in_value),
		.value_field    (value_field),
		.field_done     (field_done),
		.done_field     (done_field),
		.line_end       (line_end),
		.line_ok        (line_ok),
		.status_value   (status_value),
		.body_bytes     (body_bytes),
		.body_saturated (body_saturated)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// input transfer is noted before the result of the same edge is checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_byte(line_byte, last_byte);
			end
			if (out_valid && out_ready) begin
				sb.check_result({in_value, value_field, field_done, done_field, line_end,
					line_ok, status_value, body_bytes, body_saturated});
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random back-pressure plus one long hold-off on request
	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		line_byte <= b;
		last_byte <= l;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_line();
		foreach (line_q[i]) begin
			send_byte(line_q[i], i == line_q.size() - 1);
		end
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) begin
			line_q.push_back(s[i]);
		end
	endtask

	task automatic push_spaces(input int n);
		repeat (n) line_q.push_back(CH_SPACE);
	endtask

	task automatic push_digits(input int n);
		repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic push_addr(input int n);
		string chars;
		chars = "0123456789abcdef.:";
		repeat (n) line_q.push_back(chars[$urandom_range(chars.len() - 1)]);
	endtask

	// any content but the closing mark
	task automatic push_wrapped(input logic [7:0] open_mark, input logic [7:0] close_mark,
			input int n);
		logic [7:0] b;
		line_q.push_back(open_mark);
		repeat (n) begin
			do b = 8'($urandom_range(255)); while (b == close_mark);
			line_q.push_back(b);
		end
		line_q.push_back(close_mark);
	endtask

	// byte that ends a run field, mostly a space
	task automatic push_term(input logic [3:0] f);
		logic [7:0] b;
		if (f == FIELD_USER || $urandom_range(99) < 80) begin
			line_q.push_back(CH_SPACE);
		end else begin
			do b = 8'($urandom_range(255)); while (log_line_scoreboard::run_char_ok(f, b));
			line_q.push_back(b);
		end
	endtask

	task automatic build_good_line();
		logic [7:0] b;
		int n;
		line_q.delete();
		push_spaces($urandom_range(0, 1));
		push_addr($urandom_range(1, 8));
		push_term(FIELD_ADDR);
		if ($urandom_range(1)) begin
			repeat ($urandom_range(1, 2)) line_q.push_back(CH_DASH);
			push_spaces($urandom_range(1, 2));
		end
		do b = 8'($urandom_range(255)); while (b == CH_SPACE || b == CH_DASH);
		line_q.push_back(b);
		repeat ($urandom_range(0, 3)) begin
			do b = 8'($urandom_range(255)); while (b == CH_SPACE);
			line_q.push_back(b);
		end
		push_term(FIELD_USER);
		push_spaces($urandom_range(0, 2));
		push_wrapped(CH_LBRACK, CH_RBRACK, $urandom_range(0, 6));
		push_spaces($urandom_range(0, 2));
		push_wrapped(CH_QUOTE, CH_QUOTE, $urandom_range(0, 6));
		push_spaces($urandom_range(0, 2));
		n = 3;
		if ($urandom_range(99) < 10) begin
			n = $urandom_range(1, 4);
			if (n >= 3) n++;
		end
		push_digits(n);
		push_term(FIELD_STATUS);
		push_spaces($urandom_range(0, 2));
		if ($urandom_range(99) < 15) begin
			// around the saturation point of the body count
			if ($urandom_range(1)) begin
				push_str("429496729");
				push_digits(1);
			end else begin
				push_digits($urandom_range(9, 12));
			end
		end else begin
			push_digits($urandom_range(1, 4));
		end
		push_term(FIELD_BODY);
		repeat (3) begin
			push_spaces($urandom_range(0, 2));
			push_wrapped(CH_QUOTE, CH_QUOTE, $urandom_range(0, 5));
		end
		if ($urandom_range(99) < 20) begin
			repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(255)));
		end
		n = $urandom_range(99);
		if (n < 15) begin
			n = $urandom_range(1, line_q.size() - 1);
			while (line_q.size() > n) void'(line_q.pop_back());
		end else if (n < 25) begin
			line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
		end
	endtask

	task automatic build_noise_line();
		string chars;
		chars = "09:.af -[]\"";
		line_q.delete();
		repeat ($urandom_range(1, 12)) begin
			if ($urandom_range(1)) begin
				line_q.push_back(chars[$urandom_range(chars.len() - 1)]);
			end else begin
				line_q.push_back(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		int base;
		int goal;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 45;
		// byte extremes as one-byte lines, a run cut by the line end
		line_q.delete();
		line_q.push_back(8'h00);
		send_line();
		line_q.delete();
		line_q.push_back(8'hff);
		send_line();
		line_q.delete();
		push_str("a");
		send_line();
		// smallest good line, highest status, a byte after the last field
		line_q.delete();
		push_str("1 x [] \"\" 999 0 \"\" \"\" \"\" z");
		send_line();

		base = sb.live_bytes;
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 24 : (p == 1) ? 45 : 0;
			recv_idle_pct = (p == 0) ? 45 : (p == 1) ? 24 : 0;
			if (p == 1) hold_off = 1;
			goal = base + (p + 1) * RANDOM_ITEMS / 3;
			while (sb.live_bytes < goal) begin
				if ($urandom_range(99) < 75) begin
					build_good_line();
				end else begin
					build_noise_line();
				end
				send_line();
			end
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_results.size() != 0) begin
			sb.errors++;
			$display("%0t results still pending: expected 0, actual %0d", $time,
				sb.pending_results.size());
		end
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
